/* src/lfu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, widths and codes for the LFU key-value table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int CAP_W           = 5;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int REG_INDEX_W     = CFG_ADDR_W - 2;

    localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
    localparam logic [REG_INDEX_W-1:0]    REG_CAPACITY = 1'b0;
    localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

    typedef enum logic [0:0] {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } lfu_mode_t;

    typedef enum logic [1:0] {
        SEL_MATCH  = 2'd0,
        SEL_FREE   = 2'd1,
        SEL_VICTIM = 2'd2
    } lfu_sel_t;

    typedef enum logic [1:0] {
        RES_VALUE = 2'd0,
        RES_MISS  = 2'd1,
        RES_ZERO  = 2'd2
    } lfu_res_t;

    typedef struct packed {
        logic                      mode;
        logic signed [KEY_W-1:0]   lookup_key;
        logic signed [VALUE_W-1:0] write_value;
    } lfu_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
    } lfu_rsp_t;

    typedef struct packed {
        logic     capture;
        logic     lookup;
        logic     ram_read;
        logic     apply;
        lfu_sel_t sel;
        logic     kind_load;
        lfu_res_t kind;
        logic     search_start;
        logic     search_step;
        logic     result_load;
    } lfu_cmd_t;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic cap_zero;
        logic full;
        logic search_last;
        logic out_free;
    } lfu_status_t;

endpackage
`default_nettype wire

/* src/lfu_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* src/lfu_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_regs
// APB-style configuration register: capacity in use.
// ----------------------------------------------------------------------------
module lfu_regs
    import lfu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CAP_W-1:0]      capacity
);

    logic [CAP_W-1:0]       capacity_reg;
    logic [REG_INDEX_W-1:0] reg_index;
    logic                   wr_beat;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign wr_beat   = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign capacity  = capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (wr_beat && reg_index == REG_CAPACITY)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CAPACITY: prdata = {{(CFG_DATA_W-CAP_W){1'b0}}, capacity_reg};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* src/lfu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: lookup, decision, victim search, update and result hand-off.
// ----------------------------------------------------------------------------
module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire lfu_status_t status,
    output lfu_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOKUP = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SEARCH = 6'b001000,
        S_EVICT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_MATCH;
        cmd.kind   = RES_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.kind_load = 1'b1;
                state_next    = S_FINISH;
                if (!status.is_put)
                begin
                    if (status.hit)
                    begin
                        cmd.ram_read = 1'b1;
                        cmd.apply    = 1'b1;
                        cmd.sel      = SEL_MATCH;
                        cmd.kind     = RES_VALUE;
                    end
                    else
                    begin
                        cmd.kind = RES_MISS;
                    end
                end
                else if (status.cap_zero)
                begin
                    cmd.kind = RES_ZERO;
                end
                else if (status.hit)
                begin
                    cmd.apply = 1'b1;
                    cmd.sel   = SEL_MATCH;
                end
                else if (status.full)
                begin
                    cmd.search_start = 1'b1;
                    state_next       = S_SEARCH;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    cmd.sel   = SEL_FREE;
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_last)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.apply  = 1'b1;
                cmd.sel    = SEL_VICTIM;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/lfu_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry cells (key, use count, recency rank), value RAM, bit-serial
// victim search and the result register.
// ----------------------------------------------------------------------------
module lfu_dpath
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lfu_req_t         req,
    input  wire logic [CAP_W-1:0] capacity,
    input  wire lfu_cmd_t         cmd,
    output lfu_status_t           status,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output lfu_rsp_t              rsp
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int SKEY_W = COUNT_W + RANK_W;
    localparam int SBIT_W = $clog2(SKEY_W);

    logic                      mode_reg;
    logic signed [KEY_W-1:0]   key_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic                      hit_reg;
    lfu_res_t                  kind_reg;
    logic [MAX_ENTRIES-1:0]    match_reg;
    logic [MAX_ENTRIES-1:0]    alive_reg;
    logic [SBIT_W-1:0]         bit_reg;
    logic [OCC_W-1:0]          occ_reg;
    logic                      rsp_valid_reg;
    lfu_rsp_t                  rsp_reg;

    logic signed [KEY_W-1:0] key_cell_reg   [MAX_ENTRIES];
    logic [COUNT_W-1:0]      count_cell_reg [MAX_ENTRIES];
    logic [RANK_W-1:0]       rank_cell_reg  [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] col_vec;
    logic [MAX_ENTRIES-1:0] zero_vec;
    logic [MAX_ENTRIES-1:0] sel_vec;
    logic [IDX_W-1:0]       sel_idx;
    logic [RANK_W-1:0]      old_rank;
    logic                   fresh;
    logic                   new_entry;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       occ_ext;
    logic [VALUE_W-1:0]     ram_rdata;
    logic                   ram_we;

    assign fresh     = (cmd.sel == SEL_FREE);
    assign new_entry = (cmd.sel != SEL_MATCH);
    assign ram_we    = cmd.apply && (mode_reg == MODE_PUT);

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic [SKEY_W-1:0] skey;
        assign skey         = {count_cell_reg[g], ~rank_cell_reg[g]};
        assign valid_vec[g] = (OCC_W'(g) < occ_reg);
        assign match_vec[g] = valid_vec[g] && (key_cell_reg[g] == key_reg);
        assign free_vec[g]  = (IDX_W'(g) == occ_reg[IDX_W-1:0]);
        assign col_vec[g]   = skey[bit_reg];
    end

    assign zero_vec = alive_reg & ~col_vec;

    always_comb
    begin
        case (cmd.sel)
            SEL_MATCH:  sel_vec = match_reg;
            SEL_FREE:   sel_vec = free_vec;
            SEL_VICTIM: sel_vec = alive_reg;
            default:    sel_vec = '0;
        endcase
    end

    always_comb
    begin
        sel_idx  = '0;
        old_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (sel_vec[i])
            begin
                sel_idx  = sel_idx | IDX_W'(i);
                old_rank = old_rank | rank_cell_reg[i];
            end
        end
    end

    assign cap_ext = CMP_W'(capacity);
    assign occ_ext = CMP_W'(occ_reg);
    assign eff_cap = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;

    assign status.is_put      = (mode_reg == MODE_PUT);
    assign status.hit         = hit_reg;
    assign status.cap_zero    = (capacity == '0);
    assign status.full        = (occ_ext >= eff_cap);
    assign status.search_last = (bit_reg == '0);
    assign status.out_free    = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.lookup_key;
            val_reg  <= req.write_value;
        end
        if (cmd.lookup)
        begin
            hit_reg <= |match_vec;
        end
        if (cmd.kind_load)
        begin
            kind_reg <= cmd.kind;
        end
        if (cmd.result_load)
        begin
            rsp_reg.hit <= hit_reg;
            case (kind_reg)
                RES_VALUE: rsp_reg.read_value <= ram_rdata;
                RES_MISS:  rsp_reg.read_value <= MISS_VALUE;
                default:   rsp_reg.read_value <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cmd.apply)
            begin
                if (sel_vec[i])
                begin
                    rank_cell_reg[i] <= '0;
                    if (new_entry)
                    begin
                        key_cell_reg[i]   <= key_reg;
                        count_cell_reg[i] <= COUNT_W'(1);
                    end
                    else if (count_cell_reg[i] != '1)
                    begin
                        count_cell_reg[i] <= count_cell_reg[i] + 1'b1;
                    end
                end
                else if (valid_vec[i] && (fresh || rank_cell_reg[i] < old_rank))
                begin
                    rank_cell_reg[i] <= rank_cell_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= '0;
            alive_reg     <= '0;
            bit_reg       <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                match_reg <= match_vec;
            end
            if (cmd.search_start)
            begin
                alive_reg <= valid_vec;
                bit_reg   <= SBIT_W'(SKEY_W - 1);
            end
            else if (cmd.search_step)
            begin
                if (|zero_vec)
                begin
                    alive_reg <= zero_vec;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            if (cmd.apply && fresh)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.result_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    lfu_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_idx),
        .wdata (val_reg),
        .re    (cmd.ram_read),
        .raddr (sel_idx),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_match_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("lookup matched more than one entry");

    a_victim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && cmd.sel == SEL_VICTIM) |-> $onehot(alive_reg))
        else $error("victim search did not settle on one entry");

    a_fresh_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && cmd.sel == SEL_FREE) |-> (occ_reg < OCC_W'(MAX_ENTRIES)))
        else $error("insert into a full table");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= OCC_W'(MAX_ENTRIES)))
        else $error("occupancy beyond table size");

endmodule
`default_nettype wire

/* src/lfu_cache_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table
// LFU key-value table with least-recently-touched tie-break.
//
// Request channel (req_valid / req_stall / req) carries one get or put per
// beat; response channel (rsp_valid / rsp_stall / rsp) returns one beat per
// request, in order. A request is taken only when the sequencer is idle.
// A get, a put hit or an insert into a free slot passes the lookup, decide and
// finish states before its response is loaded. A put that must evict adds a
// bit-serial minimum search over use count and recency, one bit of the
// COUNT_W + log2(MAX_ENTRIES) bit sort key per step, then an evict state.
// A finished response waits in an output register while rsp_stall is high;
// the block holds it there and takes no new request until it has been loaded.
// Reset empties the table at once (occupancy zero) and sets capacity to 16.
// The capacity register lies at byte address 0 of the APB-style port.
// ----------------------------------------------------------------------------
module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire lfu_req_t              req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output lfu_rsp_t                   rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    lfu_cmd_t         cmd;
    lfu_status_t      status;
    logic [CAP_W-1:0] capacity;

    lfu_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lfu_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .capacity  (capacity),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

/* test/lfu_cache_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_test
// Self-checking bench for the LFU key-value table. A directed table of gets,
// puts and capacity writes runs first. A heavy-use run on one key follows,
// then random phases over a small key set per capacity setting. Every
// response beat is checked against the expected values of the directed
// table or else against an in-bench model of the table. Both channels idle at
// random, and the response side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module lfu_cache_table_test;
    import lfu_pkg::*;

    localparam int ENTRIES      = MAX_ENTRIES_DEF;
    localparam int COUNT_TOP    = 65535;
    localparam int HOT_TOUCHES  = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 128;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE       = 60;
    localparam int PLAN_ROWS    = 24;

    typedef struct {
        bit         cfg;
        logic [4:0] cap;
        lfu_req_t   req;
        bit         known;
        lfu_rsp_t   rsp;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    lfu_req_t              req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    lfu_rsp_t              rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // table model
    logic        tbl_valid [ENTRIES];
    logic [31:0] tbl_key   [ENTRIES];
    logic [31:0] tbl_value [ENTRIES];
    int          tbl_count [ENTRIES];
    int          tbl_rank  [ENTRIES];
    int          tbl_occupied;
    logic [4:0]  capacity;

    lfu_rsp_t    pending_rsp_q[$];
    int          mismatch_count;
    int          burst_left;
    int          quiet_cycles;
    int          hold_requests;
    logic [31:0] key_pool[32];
    int          pool_size;
    plan_row_t   plan[PLAN_ROWS];
    logic [4:0]  phase_caps[PHASES];

    lfu_cache_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $realtime);
    endfunction

    function automatic void touch_entry(int s);
        int old_rank;
        old_rank = tbl_rank[s];
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && i != s && tbl_rank[i] < old_rank)
                tbl_rank[i]++;
        end
        tbl_rank[s] = 0;
    endfunction

    function automatic void bump_entry(int s);
        if (tbl_count[s] < COUNT_TOP)
            tbl_count[s]++;
        touch_entry(s);
    endfunction

    function automatic lfu_rsp_t lfu_predict(lfu_req_t r);
        lfu_rsp_t e;
        int       slot;
        int       victim;
        int       free_slot;
        int       eff_cap;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == r.lookup_key)
                slot = i;
        end
        eff_cap = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
        e.hit = (slot >= 0);
        if (r.mode == MODE_GET)
        begin
            e.read_value = MISS_VALUE;
            if (slot >= 0)
            begin
                bump_entry(slot);
                e.read_value = tbl_value[slot];
            end
            return e;
        end
        e.read_value = '0;
        if (eff_cap == 0)
            return e;
        if (slot >= 0)
        begin
            tbl_value[slot] = r.write_value;
            bump_entry(slot);
            return e;
        end
        if (tbl_occupied >= eff_cap)
        begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
                    (tbl_count[i] == tbl_count[victim] && tbl_rank[i] > tbl_rank[victim])))
                    victim = i;
            end
            if (victim >= 0)
            begin
                tbl_key[victim]   = r.lookup_key;
                tbl_value[victim] = r.write_value;
                tbl_count[victim] = 1;
                touch_entry(victim);
                return e;
            end
        end
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (free_slot < 0 && !tbl_valid[i])
                free_slot = i;
        end
        if (free_slot < 0)
            return e;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i])
                tbl_rank[i]++;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot]   = r.lookup_key;
        tbl_value[free_slot] = r.write_value;
        tbl_count[free_slot] = 1;
        tbl_rank[free_slot]  = 0;
        tbl_occupied++;
        return e;
    endfunction

    function automatic plan_row_t op_row(lfu_mode_t m, logic [31:0] k, logic [31:0] v,
                                         bit known, logic h, logic [31:0] rv);
        plan_row_t row;
        row.cfg             = 1'b0;
        row.cap             = '0;
        row.req.mode        = m;
        row.req.lookup_key  = k;
        row.req.write_value = v;
        row.known           = known;
        row.rsp.hit         = h;
        row.rsp.read_value  = rv;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [4:0] c);
        plan_row_t row;
        row     = op_row(MODE_GET, '0, '0, 1'b0, 1'b0, '0);
        row.cfg = 1'b1;
        row.cap = c;
        return row;
    endfunction

    function automatic lfu_req_t random_req();
        lfu_req_t r;
        r.mode        = ($urandom_range(0, 99) < 45) ? MODE_PUT : MODE_GET;
        r.lookup_key  = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : key_pool[$urandom_range(0, pool_size - 1)];
        r.write_value = $urandom;
        return r;
    endfunction

    task automatic send_req(input lfu_req_t r, input bit known, input lfu_rsp_t typed);
        lfu_rsp_t e;
        @(negedge clk);
        if (burst_left == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 12);
        end
        req       = r;
        req_valid = 1'b1;
        do @(posedge clk); while (req_stall !== 1'b0);
        e = lfu_predict(r);
        pending_rsp_q.push_back(known ? typed : e);
        burst_left--;
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        drain_results();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'(REG_CAPACITY) << 2;
        pwdata  = CFG_DATA_W'(v);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        capacity = v;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== CFG_DATA_W'(v))
            note_mismatch("capacity readback", CFG_DATA_W'(v), prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic fill_key_pool(input int span);
        pool_size = (span > 32) ? 32 : span;
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 3))
                0:       key_pool[i] = $urandom_range(0, 15);
                1:       key_pool[i] = ($urandom_range(0, 1) == 1) ? 32'h8000_0000
                                                                    : 32'h7fff_ffff;
                default: key_pool[i] = $urandom;
            endcase
        end
    endtask

    // response side: stall pattern, plus one long hold-off on request
    initial
    begin
        int seg_left;
        int period;
        int duty;
        int tick;
        int hold_left;
        int holds_seen;
        rsp_stall  = 1'b0;
        seg_left   = 0;
        period     = 1;
        duty       = 0;
        tick       = 0;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                hold_left  = LONG_HOLD;
                holds_seen = hold_requests;
            end
            if (hold_left > 0)
            begin
                rsp_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    period   = $urandom_range(1, 8);
                    duty     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, period);
                    seg_left = $urandom_range(50, 300);
                end
                rsp_stall = ((tick % period) < duty);
                tick++;
                seg_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        lfu_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                note_mismatch("unexpected response", '0, rsp.read_value);
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.hit !== want.hit)
                    note_mismatch("hit", want.hit, rsp.hit);
                if (rsp.read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, rsp.read_value);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** lfu_cache_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        lfu_rsp_t   none;
        lfu_req_t   r;
        logic [4:0] cap_now;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_requests  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        burst_left     = 0;
        none           = '0;
        capacity       = CAP_RESET;
        tbl_occupied   = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_count[i] = 0;
            tbl_rank[i]  = 0;
        end

        plan = '{
            op_row(MODE_GET, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, MISS_VALUE),
            op_row(MODE_GET, 32'h7fff_ffff, 32'h0000_0000, 1, 1'b0, MISS_VALUE),
            op_row(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff, 1, 1'b0, 32'h0),
            op_row(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000, 1, 1'b0, 32'h0),
            op_row(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1, 1'b1, 32'h7fff_ffff),
            op_row(MODE_GET, 32'h7fff_ffff, 32'hffff_ffff, 1, 1'b1, 32'h8000_0000),
            op_row(MODE_PUT, 32'h7fff_ffff, 32'hffff_ffff, 1, 1'b1, 32'h0),
            op_row(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff, 1, 1'b0, 32'h0),
            op_row(MODE_GET, 32'hffff_ffff, 32'h0000_0000, 1, 1'b1, 32'hffff_ffff),
            op_row(MODE_GET, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, MISS_VALUE),
            cfg_row(5'd2),
            op_row(MODE_PUT, 32'h0000_0005, 32'h0000_0037, 1, 1'b0, 32'h0),
            op_row(MODE_GET, 32'h8000_0000, 32'h0000_0000, 1, 1'b0, MISS_VALUE),
            op_row(MODE_GET, 32'hffff_ffff, 32'h0000_0000, 1, 1'b1, 32'hffff_ffff),
            cfg_row(5'd0),
            op_row(MODE_PUT, 32'h0000_0009, 32'h0000_0001, 1, 1'b0, 32'h0),
            op_row(MODE_GET, 32'h0000_0009, 32'h0000_0000, 1, 1'b0, MISS_VALUE),
            op_row(MODE_GET, 32'h0000_0005, 32'h0000_0000, 1, 1'b1, 32'h0000_0037),
            op_row(MODE_PUT, 32'h0000_0005, 32'h0000_0042, 1, 1'b1, 32'h0),
            op_row(MODE_GET, 32'h0000_0005, 32'h0000_0000, 1, 1'b1, 32'h0000_0037),
            cfg_row(5'd31),
            op_row(MODE_PUT, 32'h0000_0064, 32'h0000_0001, 1, 1'b0, 32'h0),
            op_row(MODE_GET, 32'h0000_0064, 32'h0000_0000, 1, 1'b1, 32'h0000_0001),
            cfg_row(5'd16)
        };
        phase_caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16, 5'd0, 5'd9};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].cfg)
                write_capacity(plan[i].cap);
            else
                send_req(plan[i].req, plan[i].known, plan[i].rsp);
        end

        // raise one key's count well above the rest, then check it survives eviction
        write_capacity(5'd2);
        r.mode        = MODE_PUT;
        r.lookup_key  = 32'h1234_5678;
        r.write_value = 32'h0bad_cafe;
        send_req(r, 0, none);
        r.mode = MODE_GET;
        for (int i = 0; i < HOT_TOUCHES; i++)
            send_req(r, 0, none);
        for (int i = 0; i < 3; i++)
        begin
            r.mode        = MODE_PUT;
            r.lookup_key  = 32'h0000_0100 + i;
            r.write_value = $urandom;
            send_req(r, 0, none);
            r.mode       = MODE_GET;
            r.lookup_key = 32'h1234_5678;
            send_req(r, 0, none);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            cap_now = (p == PHASES - 1) ? 5'($urandom_range(0, 16)) : phase_caps[p];
            write_capacity(cap_now);
            fill_key_pool($urandom_range(2, int'(cap_now > 16 ? 16 : cap_now) + 8));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 20)
                    hold_requests++;
                if (p == 5 && i == 60)
                    drain_results();
                send_req(random_req(), 0, none);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("** lfu_cache_table: PASSED **");
        else
            $display("** lfu_cache_table: FAILED **");
        $finish;
    end

endmodule

/* lfu_cache_table.f */
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_regs.sv
src/lfu_ctrl.sv
src/lfu_dpath.sv
src/lfu_cache_table.sv
test/lfu_cache_table_test.sv
